// ===== rtl/csvt_pkg.sv =====
// Shared types and constants for the CSV stream tokenizer.
`timescale 1ns / 1ps

package csvt_pkg;

   localparam int MAX_COLUMNS_DEFAULT = 64;
   localparam int FIELDS_W = 7;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;

   localparam logic [7:0] DELIM_RESET   = 8'd44;
   localparam logic       QUOTES_RESET  = 1'b1;
   localparam logic [6:0] COLUMNS_RESET = 7'd16;

   typedef enum logic [1:0] {
      KIND_DATA   = 2'd0,
      KIND_FIELD  = 2'd1,
      KIND_RECORD = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      QS_NORMAL = 2'd0,
      QS_QUOTED = 2'd1,
      QS_AFTER  = 2'd2
   } quote_state_type;

   typedef enum logic [1:0] {
      CSR_DELIMITER = 2'd0,
      CSR_USE_QUOTES = 2'd1,
      CSR_COLUMNS   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  out_byte;
      kind_type    out_kind;
      logic        short_record;
      logic        last_of_run;
   } result_type;

   typedef struct packed {
      logic            emit;
      logic [7:0]      out_byte;
      kind_type        out_kind;
      quote_state_type qs;
      logic [FIELDS_W-1:0] fields;
   } char_step_type;

endpackage

// ===== rtl/csv_stream_tokenizer_core.sv =====
// Top level of the CSV stream tokenizer: request register, parse logic, result queue.
`timescale 1ns / 1ps

// Usage:
//   Request channel (req_*): one raw byte per request, or an end-of-stream mark
//   when req_is_end is high. A request is taken when req_valid is high and
//   req_stall is low.
//   Result channel (rsp_*): field data bytes, field-end and record-end marks,
//   one per cycle while rsp_stall is low. rsp_last_of_run flags the final
//   result caused by one request.
//   CSR channel (csr_*): index 0 delimiter, 1 quote enable, 2 column count;
//   csr_ready is always high. Write only while the block is idle.
// Path: a request is registered, then parsed into a four-entry result queue once
//   the queue has room; its results show on rsp_* from the queue registers.
// Throughput: one request per cycle while the queue has room, limited by the result
//   port, which moves one result per cycle while rsp_stall is low; a request that yields
//   two results (a held carriage return replayed before a byte, or a field end plus
//   record end) uses the port twice. Reset: synchronous; clears parse state and the queue,
//   loads CSR defaults (comma, quoting on, 16 columns).
// Stall: when rsp_stall leaves fewer than two free queue entries, the request register
//   holds and req_stall rises; nothing is lost or repeated.
module csv_stream_tokenizer_core #(
   parameter int MAX_COLUMNS = csvt_pkg::MAX_COLUMNS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_in_byte,
   input  logic               req_is_end,
   // result channel
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [7:0]         rsp_out_byte,
   output csvt_pkg::kind_type rsp_out_kind,
   output logic               rsp_short_record,
   output logic               rsp_last_of_run,
   // CSR write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   import csvt_pkg::*;

   localparam int CW = 11;
   localparam logic [CW-1:0] MAX_W = CW'(MAX_COLUMNS);
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   // CSR registers
   logic [7:0] delim_ff;
   logic       use_quotes_ff;
   logic [6:0] columns_ff;

   // request register
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;

   // parse state
   quote_state_type     qs_ff, qs_in;
   logic                cr_ff, cr_in;
   logic [FIELDS_W-1:0] fields_ff, fields_in;
   logic                nonempty_ff, nonempty_in;

   // result queue
   result_type          queue_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   logic                accept, proc_go, pop;
   logic [CW-1:0]       cols_wide, eff_cols;
   logic [FIELDS_W-1:0] limit;
   char_step_type       step_cr, step_ch;
   result_type          res0, res1;
   logic [1:0]          push_n;

   function automatic char_step_type take_char(
      input quote_state_type     qs,
      input logic [FIELDS_W-1:0] fields,
      input logic [7:0]          c,
      input logic [7:0]          delim,
      input logic                use_q,
      input logic [FIELDS_W-1:0] lim
   );
      char_step_type r;
      r.emit     = 1'b0;
      r.out_byte = c;
      r.out_kind = KIND_DATA;
      r.qs       = qs;
      r.fields   = fields;
      case (qs)
         QS_QUOTED: begin
            if (c == CHAR_QUOTE) r.qs = QS_AFTER;
            else r.emit = 1'b1;
         end
         QS_AFTER: begin
            if (c == CHAR_QUOTE) begin
               r.qs   = QS_QUOTED;
               r.emit = 1'b1;
            end else if (c == delim) begin
               r.qs = QS_NORMAL;
               if (fields < lim) begin
                  r.emit     = 1'b1;
                  r.out_byte = 8'd0;
                  r.out_kind = KIND_FIELD;
                  r.fields   = fields + 1'b1;
               end
            end else begin
               r.qs   = QS_NORMAL;
               r.emit = 1'b1;
            end
         end
         default: begin
            r.qs = QS_NORMAL;
            if (c == CHAR_QUOTE) begin
               if (use_q) r.qs = QS_QUOTED;
               else r.emit = 1'b1;
            end else if (c == delim) begin
               if (fields < lim) begin
                  r.emit     = 1'b1;
                  r.out_byte = 8'd0;
                  r.out_kind = KIND_FIELD;
                  r.fields   = fields + 1'b1;
               end
            end else begin
               r.emit = 1'b1;
            end
         end
      endcase
      return r;
   endfunction

   // CSR port
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         delim_ff      <= DELIM_RESET;
         use_quotes_ff <= QUOTES_RESET;
         columns_ff    <= COLUMNS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_DELIMITER:  delim_ff      <= csr_wdata;
            CSR_USE_QUOTES: use_quotes_ff <= csr_wdata[0];
            CSR_COLUMNS:    columns_ff    <= csr_wdata[6:0];
            default:        ;
         endcase
      end
   end

   // effective column count: 0 acts as 1, clamp to MAX_COLUMNS
   always_comb begin
      cols_wide = {{(CW-7){1'b0}}, columns_ff};
      if (columns_ff == 7'd0) eff_cols = CW'(1);
      else if (cols_wide > MAX_W) eff_cols = MAX_W;
      else eff_cols = cols_wide;
      limit = FIELDS_W'(eff_cols - CW'(1));
   end

   // handshake
   assign proc_go   = in_valid_ff && (count_ff <= QCNT_W'(QDEPTH - 2));
   assign req_stall = in_valid_ff && !proc_go;
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      in_valid_in = accept || (in_valid_ff && !proc_go);
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_is_end;
      end
   end

   // parse one request
   always_comb begin
      step_cr = take_char(qs_ff, fields_ff, CHAR_CR, delim_ff, use_quotes_ff, limit);
      if (cr_ff) begin
         step_ch = take_char(step_cr.qs, step_cr.fields, in_byte_ff, delim_ff,
                             use_quotes_ff, limit);
      end else begin
         step_ch = take_char(qs_ff, fields_ff, in_byte_ff, delim_ff,
                             use_quotes_ff, limit);
      end

      qs_in       = qs_ff;
      cr_in       = cr_ff;
      fields_in   = fields_ff;
      nonempty_in = nonempty_ff;
      push_n      = 2'd0;
      res0        = '{out_byte: 8'd0, out_kind: KIND_FIELD, short_record: 1'b0,
                      last_of_run: 1'b0};
      res1        = '{out_byte: 8'd0, out_kind: KIND_RECORD,
                      short_record: (fields_ff < limit), last_of_run: 1'b1};

      if (proc_go) begin
         if (in_end_ff || in_byte_ff == CHAR_LF) begin
            if (!in_end_ff || nonempty_ff) push_n = 2'd2;
            qs_in       = QS_NORMAL;
            cr_in       = 1'b0;
            fields_in   = '0;
            nonempty_in = 1'b0;
         end else if (in_byte_ff == CHAR_NUL) begin
            // drop
         end else if (in_byte_ff == CHAR_CR) begin
            if (cr_ff) begin
               qs_in     = step_cr.qs;
               fields_in = step_cr.fields;
               if (step_cr.emit) begin
                  push_n = 2'd1;
                  res0   = '{out_byte: step_cr.out_byte, out_kind: step_cr.out_kind,
                             short_record: 1'b0, last_of_run: 1'b1};
               end
            end
            cr_in       = 1'b1;
            nonempty_in = 1'b1;
         end else begin
            qs_in       = step_ch.qs;
            fields_in   = step_ch.fields;
            cr_in       = 1'b0;
            nonempty_in = 1'b1;
            // replay a held carriage return ahead of this byte
            if (cr_ff && step_cr.emit) begin
               res0 = '{out_byte: step_cr.out_byte, out_kind: step_cr.out_kind,
                        short_record: 1'b0, last_of_run: !step_ch.emit};
               res1 = '{out_byte: step_ch.out_byte, out_kind: step_ch.out_kind,
                        short_record: 1'b0, last_of_run: 1'b1};
               push_n = step_ch.emit ? 2'd2 : 2'd1;
            end else if (step_ch.emit) begin
               res0 = '{out_byte: step_ch.out_byte, out_kind: step_ch.out_kind,
                        short_record: 1'b0, last_of_run: 1'b1};
               push_n = 2'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         qs_ff       <= QS_NORMAL;
         cr_ff       <= 1'b0;
         fields_ff   <= '0;
         nonempty_ff <= 1'b0;
      end else begin
         qs_ff       <= qs_in;
         cr_ff       <= cr_in;
         fields_ff   <= fields_in;
         nonempty_ff <= nonempty_in;
      end
   end

   // result queue
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QPTR_W'(push_n);
      rd_ptr_in = rd_ptr_ff + QPTR_W'(pop);
      count_in  = count_ff + QCNT_W'(push_n) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) queue_ff[wr_ptr_ff] <= res0;
      if (push_n == 2'd2) queue_ff[wr_ptr_ff + QPTR_W'(1)] <= res1;
   end

   assign rsp_valid        = (count_ff != '0);
   assign rsp_out_byte     = queue_ff[rd_ptr_ff].out_byte;
   assign rsp_out_kind     = queue_ff[rd_ptr_ff].out_kind;
   assign rsp_short_record = queue_ff[rd_ptr_ff].short_record;
   assign rsp_last_of_run  = queue_ff[rd_ptr_ff].last_of_run;

endmodule

// ===== rtl/csvt_checker.sv =====
// Port-level checks for the CSV stream tokenizer, bound to the top level.
`timescale 1ns / 1ps

module csvt_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [7:0]         rsp_out_byte,
   input csvt_pkg::kind_type rsp_out_kind,
   input logic               rsp_short_record,
   input logic               rsp_last_of_run
);
   import csvt_pkg::*;

   // a stalled result stays valid and holds its byte, kind and last-of-run flag
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_out_kind) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

   // a record end is always the final result of its request
   a_record_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind == KIND_RECORD |-> rsp_last_of_run)
      else $error("record end not last of run");

   // marks carry a zero byte
   a_mark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_kind != KIND_DATA |-> rsp_out_byte == 8'd0)
      else $error("mark with nonzero byte");

   // short flag only on record ends
   a_short_record: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_short_record |-> rsp_out_kind == KIND_RECORD)
      else $error("short flag off a record end");

   // a popped field end that is not the last of its run is followed by a valid result
   a_record_after_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_out_kind == KIND_FIELD && !rsp_last_of_run
         |=> rsp_valid)
      else $error("second result of a run missing");

endmodule

bind csv_stream_tokenizer_core csvt_checker u_csvt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_out_kind     (rsp_out_kind),
   .rsp_short_record (rsp_short_record),
   .rsp_last_of_run  (rsp_last_of_run)
);
